// ===== src/lgu_pkg.sv =====
// ============================================================================
// lgu_pkg
// Shared types and constants of the loss and gradient unit.
// ============================================================================
package lgu_pkg;

    typedef enum logic [1:0] {
        MODE_MSE = 2'd0,
        MODE_BCE = 2'd1,
        MODE_CCE = 2'd2
    } t_mode;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_VLEN = 1'b1;

    localparam int QDEPTH = 2;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int DIV_STEPS = 49;

    typedef struct packed {
        t_mode              mode;
        logic [12:0]        n;
        logic signed [23:0] p;
        logic [23:0]        pc;
        logic signed [23:0] t;
        logic               last;
    } t_item;

    typedef struct packed {
        logic               start;
        logic signed [48:0] num;
        logic [27:0]        den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic signed [49:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [23:0] x;
    } t_ln_req;

    typedef struct packed {
        logic               busy;
        logic signed [21:0] y;
    } t_ln_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic is_sat32(input logic signed [49:0] v);
        return (v > 50'sd2147483647) || (v < -50'sd2147483648);
    endfunction

endpackage

// ===== src/lgu_if.sv =====
// ============================================================================
// lgu_if
// Request and result channels of the loss and gradient unit.
// ============================================================================
interface lgu_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] prediction;
    logic signed [23:0] target;

    modport source (output valid, output prediction, output target, input ready);
    modport sink (input valid, input prediction, input target, output ready);
endinterface

interface lgu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] gradient;
    logic signed [31:0] mean_loss;
    logic               loss_valid;
    logic               saturated;

    modport source (output valid, output gradient, output mean_loss, output loss_valid,
                    output saturated, input ready);
    modport sink (input valid, input gradient, input mean_loss, input loss_valid,
                  input saturated, output ready);
endinterface

// ===== src/loss_and_gradient_unit.sv =====
// ============================================================================
// loss_and_gradient_unit
// Loss gradient per element and mean loss per vector (MSE, BCE, CCE).
// ============================================================================
//  channel   dir  payload                                        handshake
//  i_pair    in   prediction, target (Q7.16)                     valid/ready
//  o_result  out  gradient, mean_loss, loss_valid, saturated     valid/ready
//  apb       in   loss_mode @0x0, vector_length @0x4             psel/penable
//
//  Request time is set by the 49-step divider and, except for MSE, the log
//  unit (normalize plus 24 squaring steps; BCE runs it twice). The last
//  element of a vector also waits for the mean divide.
//  Synchronous active-low reset; no clearing pass. A 2-entry queue lets
//  intake continue while the back end or the output register is stalled.
// ============================================================================
module loss_and_gradient_unit
    import lgu_pkg::*;
#(
    parameter int VECTOR_MAX = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lgu_in_if.sink      i_pair,
    lgu_out_if.source   o_result
);

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    lgu_front #(
        .VECTOR_MAX (VECTOR_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pair  (i_pair),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    lgu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    lgu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_res   (o_result)
    );

endmodule

// ===== src/lgu_front.sv =====
// ============================================================================
// lgu_front
// Register port, request intake and classification (mode, N, clamp, last).
// ============================================================================
module lgu_front
    import lgu_pkg::*;
#(
    parameter int VECTOR_MAX = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lgu_in_if.sink      i_pair,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic [1:0]  r_mode;
    logic [12:0] r_vlen;
    logic [12:0] r_count;
    logic [12:0] n_count;
    logic [12:0] n_eff;
    logic [13:0] cnt_inc;
    logic        wr;
    logic        is_last;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_VLEN) ? {19'b0, r_vlen} : {30'b0, r_mode};

    always_comb begin
        if (r_vlen == 13'd0) begin
            n_eff = 13'd1;
        end else if (32'(r_vlen) > VECTOR_MAX) begin
            n_eff = 13'(VECTOR_MAX);
        end else begin
            n_eff = r_vlen;
        end
    end

    assign cnt_inc = {1'b0, r_count} + 14'd1;
    assign is_last = cnt_inc >= {1'b0, n_eff};
    assign n_count = is_last ? 13'd0 : cnt_inc[12:0];

    assign i_pair.ready = !i_full;
    assign o_push       = i_pair.valid && !i_full;

    always_comb begin
        o_item.n    = n_eff;
        o_item.p    = i_pair.prediction;
        o_item.t    = i_pair.target;
        o_item.last = is_last;
        o_item.pc   = i_pair.prediction;
        case (r_mode)
            MODE_BCE: begin
                o_item.mode = MODE_BCE;
                if (i_pair.prediction < 24'sd1) begin
                    o_item.pc = 24'd1;
                end else if (i_pair.prediction > 24'sd65535) begin
                    o_item.pc = 24'd65535;
                end
            end
            MODE_CCE: begin
                o_item.mode = MODE_CCE;
                if (i_pair.prediction < 24'sd1) begin
                    o_item.pc = 24'd1;
                end
            end
            default: begin
                o_item.mode = MODE_MSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 2'd0;
            r_vlen  <= 13'd1;
            r_count <= 13'd0;
        end else begin
            if (wr && paddr[2] == REG_MODE) begin
                r_mode <= pwdata[1:0];
            end
            if (wr && paddr[2] == REG_VLEN) begin
                r_vlen <= pwdata[12:0];
            end
            if (o_push) begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ===== src/lgu_fifo.sv =====
// ============================================================================
// lgu_fifo
// Short queue of classified requests between front and back.
// ============================================================================
module lgu_fifo
    import lgu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_item            r_mem [QDEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = r_cnt == (AW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// ===== src/lgu_div.sv =====
// ============================================================================
// lgu_div
// Restoring divider, one quotient bit a cycle, rounds half away from zero.
// ============================================================================
module lgu_div
    import lgu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [27:0]   r_rem;
    logic [48:0]   r_q;
    logic [27:0]   r_den;
    logic          r_neg;
    logic [48:0]   mag;
    logic [28:0]   trial;
    logic          qbit;
    logic signed [49:0] qs;

    assign mag   = i_req.num[48] ? 49'(-i_req.num) : 49'(i_req.num);
    assign trial = {r_rem, r_q[48]};
    assign qbit  = trial >= {1'b0, r_den};
    assign qs    = $signed({1'b0, r_q});

    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_neg ? -qs : qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= mag + 49'(i_req.den >> 1);
            r_den <= i_req.den;
            r_neg <= i_req.num[48];
        end else if (r_busy) begin
            r_rem <= qbit ? 28'(trial - {1'b0, r_den}) : trial[27:0];
            r_q   <= {r_q[47:0], qbit};
        end
    end

endmodule

// ===== src/lgu_ln.sv =====
// ============================================================================
// lgu_ln
// Natural log of a nonzero Q16 value: normalize, 24 squaring steps, scale by ln2.
// ============================================================================
module lgu_ln
    import lgu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ln_req i_req,
    output t_ln_rsp o_rsp
);

    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_NORM = 5'b00010,
        L_SQ   = 5'b00100,
        L_MUL  = 5'b01000,
        L_RND  = 5'b10000
    } t_lst;

    t_lst               r_st;
    logic [30:0]        r_m;
    logic [4:0]         r_s;
    logic [4:0]         r_cnt;
    logic [23:0]        r_frac;
    logic [60:0]        r_prod;
    logic               r_neg;
    logic signed [21:0] r_y;
    logic [61:0]        sq;
    logic [31:0]        m2;
    logic signed [5:0]  e;
    logic signed [29:0] l2;
    logic [29:0]        mag30;
    logic [60:0]        prod;
    logic [60:0]        rs;
    logic signed [21:0] yq;

    assign sq    = r_m * r_m;
    assign m2    = sq[61:30];
    assign e     = 6'sd14 - $signed({1'b0, r_s});
    assign l2    = $signed({e, r_frac});
    assign mag30 = l2[29] ? 30'(-l2) : 30'(l2);
    assign prod  = mag30[28:0] * LN2_Q32;
    assign rs    = r_prod + (61'd1 << 39);
    assign yq    = $signed({1'b0, rs[60:40]});

    assign o_rsp.busy = r_st != L_IDLE;
    assign o_rsp.y    = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            case (r_st)
                L_IDLE: begin
                    if (i_req.start) begin
                        r_st <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (r_m[30]) begin
                        r_st <= L_SQ;
                    end
                end
                L_SQ: begin
                    if (r_cnt == 5'd23) begin
                        r_st <= L_MUL;
                    end
                end
                L_MUL:   r_st <= L_RND;
                L_RND:   r_st <= L_IDLE;
                default: r_st <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            L_IDLE: begin
                r_m <= {7'b0, i_req.x};
                r_s <= '0;
            end
            L_NORM: begin
                r_cnt  <= '0;
                r_frac <= '0;
                if (!r_m[30]) begin
                    if (r_m[30:23] == 8'd0) begin
                        r_m <= {r_m[22:0], 8'b0};
                        r_s <= r_s + 5'd8;
                    end else begin
                        r_m <= {r_m[29:0], 1'b0};
                        r_s <= r_s + 5'd1;
                    end
                end
            end
            L_SQ: begin
                r_cnt  <= r_cnt + 5'd1;
                r_m    <= m2[31] ? m2[31:1] : m2[30:0];
                r_frac <= {r_frac[22:0], m2[31]};
            end
            L_MUL: begin
                r_prod <= prod;
                r_neg  <= l2[29];
            end
            L_RND: begin
                r_y <= r_neg ? -yq : yq;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/lgu_back.sv =====
// ============================================================================
// lgu_back
// Per-request sequencer: gradient divide, log terms, loss sum, mean, output.
// ============================================================================
module lgu_back
    import lgu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_item     i_item,
    output logic      o_pop,
    lgu_out_if.source o_res
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_PRE    = 13'b0000000000010,
        ST_DEN    = 13'b0000000000100,
        ST_START  = 13'b0000000001000,
        ST_WAIT1  = 13'b0000000010000,
        ST_LN2    = 13'b0000000100000,
        ST_WAIT2  = 13'b0000001000000,
        ST_T1     = 13'b0000010000000,
        ST_T2     = 13'b0000100000000,
        ST_SUM    = 13'b0001000000000,
        ST_MSTART = 13'b0010000000000,
        ST_MWAIT  = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } t_st;

    t_st                r_st;
    t_item              r_it;
    logic signed [49:0] r_acc;
    logic [14:0]        r_den;
    logic [27:0]        r_dvsr;
    logic signed [48:0] r_num;
    logic signed [21:0] r_ln1;
    logic signed [31:0] r_grad;
    logic               r_gsat;
    logic signed [47:0] r_sum;
    logic signed [31:0] r_mean;
    logic               r_msat;
    logic               r_out_valid;
    logic signed [31:0] r_out_grad;
    logic signed [31:0] r_out_mean;
    logic               r_out_lv;
    logic               r_out_sat;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_ln_req  ln_req;
    t_ln_rsp  ln_rsp;

    logic signed [24:0] d;
    logic signed [24:0] pt;
    logic signed [24:0] ct;
    logic signed [49:0] dd;
    logic [16:0]        omp;
    logic [32:0]        bprod;
    logic signed [49:0] tl1;
    logic signed [24:0] omt;
    logic signed [49:0] tl2;
    logic [49:0]        amag;
    logic [49:0]        qr;
    logic signed [49:0] term;
    logic signed [50:0] s51;
    logic               load;

    lgu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lgu_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ln_req),
        .o_rsp   (ln_rsp)
    );

    assign d     = $signed({r_it.p[23], r_it.p}) - $signed({r_it.t[23], r_it.t});
    assign pt    = $signed({1'b0, r_it.pc}) - $signed({r_it.t[23], r_it.t});
    assign ct    = d;
    assign dd    = d * d;
    assign omp   = 17'd65536 - {1'b0, r_it.pc[15:0]};
    assign bprod = r_it.pc[15:0] * omp;
    assign tl1   = r_it.t * r_ln1;
    assign omt   = 25'sd65536 - $signed({r_it.t[23], r_it.t});
    assign tl2   = omt * ln_rsp.y;
    assign amag  = r_acc[49] ? 50'(-r_acc) : 50'(r_acc);
    assign qr    = (amag + 50'd32768) >> 16;
    // log modes negate the rounded sum; the sign of the sum picks the direction
    assign term  = ((r_it.mode == MODE_MSE) != r_acc[49]) ? $signed(qr) : -$signed(qr);
    assign s51   = 51'(r_sum) + 51'(term);

    assign o_pop = (r_st == ST_IDLE) && i_valid;
    assign load  = (r_st == ST_OUT) && (!r_out_valid || o_res.ready);

    always_comb begin
        div_req.start = (r_st == ST_START) || (r_st == ST_MSTART);
        div_req.num   = (r_st == ST_MSTART) ? 49'(r_sum) : r_num;
        div_req.den   = (r_st == ST_MSTART) ? {15'b0, r_it.n} : r_dvsr;
        ln_req.start  = ((r_st == ST_START) && (r_it.mode != MODE_MSE)) || (r_st == ST_LN2);
        ln_req.x      = (r_st == ST_LN2) ? (24'd65536 - r_it.pc) : r_it.pc;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.gradient   = r_out_grad;
    assign o_res.mean_loss  = r_out_mean;
    assign o_res.loss_valid = r_out_lv;
    assign o_res.saturated  = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_st <= ST_PRE;
                    end
                end
                ST_PRE:   r_st <= ST_DEN;
                ST_DEN:   r_st <= ST_START;
                ST_START: r_st <= ST_WAIT1;
                ST_WAIT1: begin
                    if (!div_rsp.busy && !ln_rsp.busy) begin
                        r_st <= (r_it.mode == MODE_BCE) ? ST_LN2 : ST_T1;
                    end
                end
                ST_LN2: r_st <= ST_WAIT2;
                ST_WAIT2: begin
                    if (!ln_rsp.busy) begin
                        r_st <= ST_T1;
                    end
                end
                ST_T1: r_st <= (r_it.mode == MODE_BCE) ? ST_T2 : ST_SUM;
                ST_T2: r_st <= ST_SUM;
                ST_SUM: begin
                    if (s51[50:47] != 4'b0000 && s51[50:47] != 4'b1111) begin
                        r_sum <= s51[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                    end else begin
                        r_sum <= s51[47:0];
                    end
                    r_st <= r_it.last ? ST_MSTART : ST_OUT;
                end
                ST_MSTART: begin
                    r_sum <= '0;
                    r_st  <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (!div_rsp.busy) begin
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_it <= i_item;
            end
            ST_PRE: begin
                r_acc <= dd;
                r_den <= 15'(bprod[32:16]) + 15'd1;
            end
            ST_DEN: begin
                case (r_it.mode)
                    MODE_BCE: begin
                        r_dvsr <= 28'(r_den * r_it.n);
                        r_num  <= $signed({{8{pt[24]}}, pt, 16'b0});
                    end
                    MODE_CCE: begin
                        r_dvsr <= {15'b0, r_it.n};
                        r_num  <= $signed({{24{ct[24]}}, ct});
                    end
                    default: begin
                        r_dvsr <= {15'b0, r_it.n};
                        r_num  <= $signed({{23{d[24]}}, d, 1'b0});
                    end
                endcase
            end
            ST_WAIT1: begin
                r_grad <= sat32(div_rsp.quo);
                r_gsat <= is_sat32(div_rsp.quo);
                r_ln1  <= ln_rsp.y;
            end
            ST_T1: begin
                if (r_it.mode != MODE_MSE) begin
                    r_acc <= tl1;
                end
            end
            ST_T2: begin
                r_acc <= r_acc + tl2;
            end
            ST_SUM: begin
                r_mean <= '0;
                r_msat <= 1'b0;
            end
            ST_MWAIT: begin
                r_mean <= sat32(div_rsp.quo);
                r_msat <= is_sat32(div_rsp.quo);
            end
            default: begin
            end
        endcase
        if (load) begin
            r_out_grad <= r_grad;
            r_out_mean <= r_mean;
            r_out_lv   <= r_it.last;
            r_out_sat  <= r_gsat | r_msat;
        end
    end

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_ln_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ln_req.start |-> !ln_rsp.busy)
        else $error("log unit started while busy");

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_lv) |-> (r_out_mean == 32'sd0))
        else $error("mean loss set on a non-last element");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_MSTART) |=> (r_sum == 48'sd0))
        else $error("loss sum not cleared after last element");

endmodule

// ===== tb/tb_loss_and_gradient_unit.sv =====
// ============================================================================
// tb_loss_and_gradient_unit
// Self-checking testbench of the loss and gradient unit.
// Each phase sets the loss mode, the vector length or both over APB while
// the unit is idle, then streams prediction/target requests: first directed
// extremes, then random phases. Every accepted request is run through an
// in-bench predictor, and each result is compared field by field with the
// oldest expectation. Both channels idle at random.
// ============================================================================
module tb_loss_and_gradient_unit;
    import lgu_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam longint ONE = 65536;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_REQS = 1750;

    typedef struct {
        logic signed [23:0] p;
        logic signed [23:0] t;
    } t_pair;

    typedef struct {
        logic signed [31:0] gradient;
        logic signed [31:0] mean_loss;
        logic               loss_valid;
        logic               saturated;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lgu_in_if  pair_if ();
    lgu_out_if result_if ();

    loss_and_gradient_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_pair   (pair_if),
        .o_result (result_if)
    );

    t_pair   pair_queue[$];
    t_result expected_results[$];
    logic [1:0]  mode_shadow;
    logic [12:0] vlen_shadow;
    longint      loss_sum;
    int unsigned element_count;
    int          errors;
    int          send_gap;
    int          stall_left;
    bit          idle_on;
    int          cycles;

    // ---------------------------------------------------------------- clock
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pair_if.valid = 1'b0;
        pair_if.prediction = '0;
        pair_if.target = '0;
        result_if.ready = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------ predictor
    function automatic longint div_nearest(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? longint'(-num) : longint'(num);
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint ln_q16(input longint unsigned x);
        int unsigned     k;
        longint unsigned m;
        longint unsigned frac;
        longint          log2_q24;
        k = 0;
        frac = 0;
        while (k < 63 && (x >> (k + 1)) != 0) k++;
        m = k <= 30 ? x << (30 - k) : x >> (k - 30);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        log2_q24 = (longint'(k) - 16) * 16777216 + longint'(frac);
        return div_nearest(log2_q24 * longint'(LN2_Q32), 64'd1 << 40);
    endfunction

    function automatic longint clip32(input longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_result predict_result(input logic signed [23:0] p_in,
                                               input logic signed [23:0] t_in);
        t_result r;
        longint  p;
        longint  t;
        longint  n;
        longint  pc;
        longint  den;
        longint  grad;
        longint  term;
        longint  mean;
        logic    sat;
        logic    last;
        p = p_in;
        t = t_in;
        n = vlen_shadow;
        sat = 1'b0;
        mean = 0;
        if (n == 0) n = 1;
        if (n > 4096) n = 4096;
        if (mode_shadow == MODE_BCE) begin
            pc = p < 1 ? 1 : (p > ONE - 1 ? ONE - 1 : p);
            den = ((pc * (ONE - pc)) >>> 16) + 1;
            grad = div_nearest((pc - t) * ONE, den * n);
            term = -div_nearest(t * ln_q16(pc) + (ONE - t) * ln_q16(ONE - pc), ONE);
        end else if (mode_shadow == MODE_CCE) begin
            pc = p < 1 ? 1 : p;
            grad = div_nearest(p - t, n);
            term = -div_nearest(t * ln_q16(pc), ONE);
        end else begin
            grad = div_nearest(2 * (p - t), n);
            term = div_nearest((p - t) * (p - t), ONE);
        end
        grad = clip32(grad, sat);
        loss_sum = loss_sum + term;
        if (loss_sum > SUM_HI) loss_sum = SUM_HI;
        if (loss_sum < SUM_LO) loss_sum = SUM_LO;
        last = longint'(element_count) + 1 >= n;
        if (last) begin
            mean = clip32(div_nearest(loss_sum, n), sat);
            loss_sum = 0;
            element_count = 0;
        end else begin
            element_count++;
        end
        r.gradient = grad[31:0];
        r.mean_loss = mean[31:0];
        r.loss_valid = last;
        r.saturated = sat;
        return r;
    endfunction

    // --------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (pair_if.valid && pair_if.ready) begin
                expected_results.push_back(predict_result(pair_if.prediction,
                                                          pair_if.target));
            end
            if (!pair_if.valid || pair_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pair_if.valid <= 1'b0;
                end else if (pair_queue.size() > 0) begin
                    t_pair pr;
                    pr = pair_queue.pop_front();
                    pair_if.valid <= 1'b1;
                    pair_if.prediction <= pr.p;
                    pair_if.target <= pr.t;
                    send_gap = idle_on ? $urandom_range(0, 17) : 0;
                end else begin
                    pair_if.valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result, gradient %0d", result_if.gradient);
                    errors++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (result_if.gradient !== e.gradient) begin
                        $error("gradient: expected %0d, got %0d", e.gradient,
                               result_if.gradient);
                        errors++;
                    end
                    if (result_if.mean_loss !== e.mean_loss) begin
                        $error("mean_loss: expected %0d, got %0d", e.mean_loss,
                               result_if.mean_loss);
                        errors++;
                    end
                    if (result_if.loss_valid !== e.loss_valid) begin
                        $error("loss_valid: expected %0b, got %0b", e.loss_valid,
                               result_if.loss_valid);
                        errors++;
                    end
                    if (result_if.saturated !== e.saturated) begin
                        $error("saturated: expected %0b, got %0b", e.saturated,
                               result_if.saturated);
                        errors++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------- timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------- stimulus
    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_MODE) mode_shadow = value[1:0];
        else vlen_shadow = value[12:0];
    endtask

    // checked after the edge has settled so the driver's updates are seen
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pair_queue.size() != 0 || pair_if.valid || expected_results.size() != 0);
    endtask

    task automatic push_pair(input longint p, input longint t);
        t_pair pr;
        pr.p = p[23:0];
        pr.t = t[23:0];
        pair_queue.push_back(pr);
    endtask

    function automatic longint random_prob();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 0;
        if (sel == 1) return ONE;
        if (sel == 2) return $urandom_range(0, 3);
        if (sel == 3) return ONE - $urandom_range(0, 3);
        return $urandom_range(0, ONE);
    endfunction

    function automatic longint random_full();
        logic signed [23:0] v;
        v = 24'($urandom);
        return v;
    endfunction

    initial begin
        int sent;
        int cnt;
        int pick;
        logic [12:0] vlen;
        errors = 0;
        cycles = 0;
        loss_sum = 0;
        element_count = 0;
        mode_shadow = MODE_MSE;
        vlen_shadow = 13'd1;
        idle_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed extremes, one phase per mode
        apb_write(REG_MODE, 32'(MODE_MSE));
        apb_write(REG_VLEN, 32'd1);
        push_pair(8388607, -8388608);
        push_pair(-8388608, 8388607);
        push_pair(0, 0);
        push_pair(ONE, 0);
        drain();
        apb_write(REG_MODE, 32'(MODE_BCE));
        push_pair(0, 0);
        push_pair(ONE, ONE);
        push_pair(-8388608, ONE);
        push_pair(8388607, 0);
        push_pair(32768, 8388607);
        push_pair(1, -8388608);
        drain();
        apb_write(REG_MODE, 32'(MODE_CCE));
        push_pair(0, ONE);
        push_pair(-5, ONE);
        push_pair(8388607, -8388608);
        push_pair(ONE, ONE);
        drain();
        apb_write(REG_MODE, 32'(MODE_RESERVED));
        apb_write(REG_VLEN, 32'd0);
        push_pair(100000, -3000);
        push_pair(-8388608, 8388607);
        drain();
        // length beyond the maximum, then shortened mid-vector
        apb_write(REG_VLEN, 32'd8191);
        push_pair(8388607, -8388608);
        push_pair(-8388608, 8388607);
        drain();
        apb_write(REG_VLEN, 32'd4096);
        push_pair(ONE, 0);
        drain();
        apb_write(REG_VLEN, 32'd2);
        push_pair(12345, 678);
        drain();

        // random phases
        sent = 0;
        while (sent < RANDOM_REQS) begin
            idle_on = $urandom_range(0, 3) != 0;
            apb_write(REG_MODE, $urandom_range(0, 3));
            pick = $urandom_range(0, 19);
            if (pick == 0) vlen = 13'd0;
            else if (pick == 1) vlen = 13'd4096;
            else if (pick == 2) vlen = 13'd8191;
            else if (pick == 3) vlen = 13'($urandom_range(1, 8191));
            else vlen = 13'($urandom_range(1, 12));
            apb_write(REG_VLEN, 32'(vlen));
            cnt = $urandom_range(10, 60);
            for (int i = 0; i < cnt; i++) begin
                if ($urandom_range(0, 3) == 0) push_pair(random_full(), random_full());
                else push_pair(random_prob(), random_prob());
            end
            sent += cnt;
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
